// ===== hdl/prft_pkg.sv =====
package prft_pkg;

    // Table size, priority range and hit counter width.
    localparam int TABLE_DEPTH     = 16;
    localparam int LOWEST_PRIORITY = 7;
    localparam int COUNT_BITS      = 16;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int PRI_MIN = 3;
    localparam int PRI_W   = ($clog2(LOWEST_PRIORITY + 1) > PRI_MIN) ?
                             $clog2(LOWEST_PRIORITY + 1) : PRI_MIN;
    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Command codes.
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_ADD    = 1'b1;

    // Action codes.
    localparam logic ACT_FORWARD = 1'b0;
    localparam logic ACT_DROP    = 1'b1;

    // The default rule delivers locally.
    localparam logic [PORT_W-1:0] LOCAL_PORT = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP_HIGH = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [31:0]       dest_ip;
        logic [31:0]       range_low;
        logic [31:0]       range_high;
        logic              new_action;
        logic [1:0]        new_port;
        logic [2:0]        new_priority;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic              table_full;
        logic              action_kind;
        logic [1:0]        out_port;
        logic [3:0]        rule_index;
        logic [15:0]       hit_count;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] low;
        logic [ADDR_W-1:0] high;
        logic              action;
        logic [PORT_W-1:0] port;
        logic [PRI_W-1:0]  pri;
    } rule_t;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic                  valid;
        logic [ADDR_W-1:0]     dest;
        logic                  found;
        logic [IDX_W-1:0]      best_idx;
        logic [PRI_W-1:0]      best_pri;
        logic                  action;
        logic [PORT_W-1:0]     port;
        logic [COUNT_BITS-1:0] hits;
    } token_t;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        rule_t            wr_rule;
        logic             inc_en;
        logic [IDX_W-1:0] inc_idx;
        logic             adv;
    } ctl_t;

endpackage

// ===== hdl/priority_range_flow_table_top.sv =====
// Lookup: the search token walks the row of rule cells one cell per clock unless the row
// stalls, then the result is registered. Add: the result is held in a pending register,
// then loaded into the output register. One item is in flight at a time, so no request
// is accepted until the result of a lookup or an add is loaded into the output register.
// Reset (rst_n, asynchronous, active low) leaves only the default rule in the table,
// clears every hit counter and sets both own address registers to zero.
module priority_range_flow_table_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [prft_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  prft_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output prft_pkg::rsp_t                rsp
);

    // Own address range, served by the default rule in cell 0.
    logic [31:0]                     own_low_reg;
    logic [31:0]                     own_high_reg;

    // Number of rules in use, including the default rule.
    logic [prft_pkg::CNT_W-1:0]      count_reg;
    logic [prft_pkg::CNT_W-1:0]      count_next;

    // A lookup token is somewhere in the cell row.
    logic                            busy_reg;
    logic                            busy_next;

    // An add has finished and its result waits for the output register.
    logic                            add_pend_reg;
    logic                            add_pend_next;
    prft_pkg::rsp_t                  add_res_reg;
    prft_pkg::rsp_t                  add_res_next;

    logic                            rsp_valid_reg;
    logic                            rsp_valid_next;
    prft_pkg::rsp_t                  rsp_reg;
    prft_pkg::rsp_t                  rsp_next;

    prft_pkg::token_t                tok [prft_pkg::TABLE_DEPTH+1];
    prft_pkg::token_t                head_tok;
    logic [prft_pkg::TABLE_DEPTH-1:0] tok_valid;
    prft_pkg::token_t                last_tok;
    prft_pkg::rule_t                 default_rule;
    prft_pkg::ctl_t                  ctl;

    logic                            accept;
    logic                            rsp_free;
    logic                            exit_load;
    logic                            add_load;
    logic                            table_has_room;
    logic [prft_pkg::COUNT_BITS-1:0] new_hits;

    assign accept         = req_valid && req_ready;
    assign req_ready      = !busy_reg && !add_pend_reg;
    assign rsp_free       = !rsp_valid_reg || rsp_ready;
    assign last_tok       = tok[prft_pkg::TABLE_DEPTH];
    assign exit_load      = last_tok.valid && rsp_free;
    assign add_load       = add_pend_reg && rsp_free;
    assign table_has_room = count_reg < prft_pkg::CNT_W'(prft_pkg::TABLE_DEPTH);

    // The counter of the winning rule, after a saturating increment.
    assign new_hits = (last_tok.hits == prft_pkg::COUNT_MAX) ?
                      last_tok.hits : last_tok.hits + 1'b1;

    // Cell 0 always holds the default rule built from the current configuration.
    always_comb
    begin
        default_rule.low    = own_low_reg;
        default_rule.high   = own_high_reg;
        default_rule.action = prft_pkg::ACT_FORWARD;
        default_rule.port   = prft_pkg::LOCAL_PORT;
        default_rule.pri    = prft_pkg::PRI_W'(prft_pkg::LOWEST_PRIORITY);
    end

    // A lookup enters the row as a fresh token with nothing found yet.
    always_comb
    begin
        head_tok       = '0;
        head_tok.valid = accept && (req.cmd == prft_pkg::CMD_LOOKUP);
        head_tok.dest  = req.dest_ip;
    end

    assign tok[0] = head_tok;

    // Broadcast control. The whole row stalls only when a finished token
    // sits in the last cell and the output register cannot take it.
    always_comb
    begin
        ctl.count          = count_reg;
        ctl.wr_en          = accept && (req.cmd == prft_pkg::CMD_ADD) && table_has_room;
        ctl.wr_idx         = count_reg[prft_pkg::IDX_W-1:0];
        ctl.wr_rule.low    = req.range_low;
        ctl.wr_rule.high   = req.range_high;
        ctl.wr_rule.action = req.new_action;
        ctl.wr_rule.port   = req.new_port;
        ctl.wr_rule.pri    = prft_pkg::PRI_W'(req.new_priority);
        ctl.inc_en         = exit_load && last_tok.found;
        ctl.inc_idx        = last_tok.best_idx;
        ctl.adv            = !(last_tok.valid && !rsp_free);
    end

    generate
        for (genvar i = 0; i < prft_pkg::TABLE_DEPTH; i++)
        begin : g_cell
            prft_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cell_idx   (prft_pkg::IDX_W'(i)),
                .fixed_sel  ((i == 0) ? 1'b1 : 1'b0),
                .fixed_rule (default_rule),
                .ctl        (ctl),
                .tok_in     (tok[i]),
                .tok_out    (tok[i+1])
            );
            assign tok_valid[i] = tok[i+1].valid;
        end
    endgenerate

    // Item bookkeeping: adds are settled at acceptance, lookups when the
    // token leaves the last cell.
    always_comb
    begin
        count_next     = count_reg;
        busy_next      = busy_reg;
        add_pend_next  = add_pend_reg;
        add_res_next   = add_res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (accept && (req.cmd == prft_pkg::CMD_LOOKUP))
        begin
            busy_next = 1'b1;
        end

        if (accept && (req.cmd == prft_pkg::CMD_ADD))
        begin
            add_pend_next = 1'b1;
            add_res_next  = '0;
            if (table_has_room)
            begin
                count_next              = count_reg + 1'b1;
                add_res_next.hit        = 1'b1;
                add_res_next.rule_index = 4'(count_reg);
            end
            else
            begin
                add_res_next.table_full = 1'b1;
            end
        end

        if (add_load)
        begin
            add_pend_next  = 1'b0;
            rsp_valid_next = 1'b1;
            rsp_next       = add_res_reg;
        end

        if (exit_load)
        begin
            busy_next      = 1'b0;
            rsp_valid_next = 1'b1;
            rsp_next       = '0;
            if (last_tok.found)
            begin
                rsp_next.hit         = 1'b1;
                rsp_next.action_kind = last_tok.action;
                rsp_next.out_port    = last_tok.port;
                rsp_next.rule_index  = 4'(last_tok.best_idx);
                rsp_next.hit_count   = 16'(new_hits);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_low_reg   <= '0;
            own_high_reg  <= '0;
            count_reg     <= prft_pkg::CNT_W'(1);
            busy_reg      <= 1'b0;
            add_pend_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == prft_pkg::CFG_OWN_IP_LOW))
            begin
                own_low_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == prft_pkg::CFG_OWN_IP_HIGH))
            begin
                own_high_reg <= cfg_data;
            end
            count_reg     <= count_next;
            busy_reg      <= busy_next;
            add_pend_reg  <= add_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        add_res_reg <= add_res_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    // Only one item is ever being worked on.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && add_pend_reg))
        else $error("lookup and add in flight together");

    // The cell row never carries more than one token.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tok_valid) <= 1)
        else $error("more than one token in the cell row");

    // The rule count stays between the default rule alone and a full table.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= prft_pkg::CNT_W'(1))
        && (count_reg <= prft_pkg::CNT_W'(prft_pkg::TABLE_DEPTH)))
        else $error("rule count out of range");

    // A token in the row means a lookup was accepted and is unfinished.
    a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid != '0) |-> busy_reg)
        else $error("token in the row while idle");
`endif

endmodule

// ===== hdl/prft_cell.sv =====
module prft_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [prft_pkg::IDX_W-1:0] cell_idx,
    input  logic                   fixed_sel,
    input  prft_pkg::rule_t        fixed_rule,
    input  prft_pkg::ctl_t         ctl,
    input  prft_pkg::token_t       tok_in,
    output prft_pkg::token_t       tok_out
);

    prft_pkg::rule_t                      rule_reg;
    logic [prft_pkg::COUNT_BITS-1:0]      hits_reg;
    prft_pkg::token_t                     tok_reg;
    prft_pkg::token_t                     tok_next;
    prft_pkg::rule_t                      rule_eff;
    logic                                 active;
    logic                                 in_range;
    logic                                 take;

    assign rule_eff = fixed_sel ? fixed_rule : rule_reg;
    assign active   = fixed_sel || (prft_pkg::CNT_W'(cell_idx) < ctl.count);
    assign in_range = (tok_in.dest >= rule_eff.low) && (tok_in.dest <= rule_eff.high);

    // A strictly better priority replaces the token's choice, so the earlier
    // rule keeps a tie.
    assign take = tok_in.valid && active && in_range
                  && (rule_eff.pri <= prft_pkg::PRI_W'(prft_pkg::LOWEST_PRIORITY))
                  && (!tok_in.found || (rule_eff.pri < tok_in.best_pri));

    always_comb
    begin
        tok_next = tok_in;
        if (take)
        begin
            tok_next.found    = 1'b1;
            tok_next.best_idx = cell_idx;
            tok_next.best_pri = rule_eff.pri;
            tok_next.action   = rule_eff.action;
            tok_next.port     = rule_eff.port;
            tok_next.hits     = hits_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg  <= '0;
            hits_reg <= '0;
        end
        else
        begin
            if (ctl.adv)
            begin
                tok_reg <= tok_next;
            end
            if (ctl.wr_en && (ctl.wr_idx == cell_idx))
            begin
                hits_reg <= '0;
            end
            else if (ctl.inc_en && (ctl.inc_idx == cell_idx)
                     && (hits_reg != prft_pkg::COUNT_MAX))
            begin
                hits_reg <= hits_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && (ctl.wr_idx == cell_idx))
        begin
            rule_reg <= ctl.wr_rule;
        end
    end

    assign tok_out = tok_reg;

endmodule
